// ===== rtl/core/bblru_pkg.sv =====
// ============================================================================
// bblru_pkg: shared types and constants for the byte budget LRU evictor
// Holds the operation codes, payload structs, slot record and FSM states.
// ============================================================================
package bblru_pkg;

  localparam int unsigned ENTRIES         = 16;
  localparam int unsigned IDX_W           = $clog2(ENTRIES);
  localparam int unsigned TOTAL_W         = 28;
  localparam int unsigned SIZE_W          = 24;
  localparam int unsigned STAMP_W         = 32;
  localparam int unsigned HOLD_W          = 8;
  localparam logic [SIZE_W-1:0] MAX_ASSET_BYTES = 24'd16777215;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {TOTAL_W{1'b1}};
  localparam logic [HOLD_W-1:0] HOLD_MAX        = {HOLD_W{1'b1}};

  // Slot record: size, pin, holds, stamp
  localparam int unsigned SLOT_W = SIZE_W + 1 + HOLD_W + STAMP_W;

  // Register map
  localparam logic [1:0] REG_BUDGET = 2'd0;

  typedef enum logic [2:0] {
    OP_TOUCH  = 3'd0,
    OP_PUT    = 3'd1,
    OP_HOLD   = 3'd2,
    OP_UNHOLD = 3'd3,
    OP_REMOVE = 3'd4,
    OP_EVICT  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [3:0]        entry_index;
    logic [SIZE_W-1:0] entry_size;
    logic              pin_request;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [4:0]         evicted_count;
    logic [15:0]        evicted_mask;
    logic [TOTAL_W-1:0] freed_bytes;
    logic [TOTAL_W-1:0] total_bytes;
    logic               over_budget;
    logic               over_budget_new;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic               pinned;
    logic [HOLD_W-1:0]  holds;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/byte_budget_lru_evictor.sv =====
// ============================================================================
// byte_budget_lru_evictor: size-aware LRU cache directory with byte budget
// Slot records sit in one RAM; valid bits and totals sit in flops. Put,
// unhold and evict run an eviction pass that scans the RAM for the oldest
// unpinned, unheld slot and drops it until the total fits the budget.
// ============================================================================
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | in_item (in_item_t)
//  out_    | output    | out_valid / out_stall| out_item (out_item_t)
//  cfg_    | input     | APB psel/penable     | budget_bytes at address 0
//
// Steps: an operation without eviction passes through the slot read, modify,
// check, result and idle states. Each victim adds a scan with one RAM read
// per slot visited, then a recheck; a pass that ends over budget adds one
// more scan of the slots. Reset clears valid bits, totals and the use clock
// at once; no clearing pass. A held result waits in the output register
// while out_stall is high; the next item is taken after transfer.
module byte_budget_lru_evictor (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bblru_pkg::in_item_t    in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bblru_pkg::out_item_t   out_item,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [1:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import bblru_pkg::*;

  // Control and data registers
  state_t              state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [STAMP_W-1:0]  clock_r, clock_nxt;
  logic                reported_r, reported_nxt;
  logic [TOTAL_W-1:0]  budget_r;
  out_item_t           res_r, res_nxt;
  logic                hit_r, hit_nxt;
  logic                evict_r, evict_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;
  slot_t               pick_slot_r, pick_slot_nxt;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_wdata;
  slot_t            ram_rdata;

  bblru_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr)
      REG_BUDGET: cfg_prdata = {{(32-TOTAL_W){1'b0}}, budget_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= TOTAL_MAX;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_BUDGET) begin
      budget_r <= cfg_pwdata[TOTAL_W-1:0];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_item  = res_r;

  // Candidate test on the word read this cycle
  logic [IDX_W-1:0] rd_idx;
  logic             cand;
  logic             older;
  logic [SIZE_W-1:0] old_size;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W:0]   new_sum;
  slot_t            upd;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    valid_nxt     = valid_r;
    total_nxt     = total_r;
    clock_nxt     = clock_r;
    reported_nxt  = reported_r;
    res_nxt       = res_r;
    hit_nxt       = hit_r;
    evict_nxt     = evict_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_slot_nxt = pick_slot_r;
    ram_we        = 1'b0;
    ram_waddr     = item_r.entry_index[IDX_W-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = item_r.entry_index[IDX_W-1:0];
    upd           = ram_rdata;
    rd_idx        = scan_r - IDX_W'(1);
    cand          = valid_r[rd_idx] && !ram_rdata.pinned && ram_rdata.holds == '0;
    older         = !found_r || (ram_rdata.stamp < pick_slot_r.stamp);
    old_size      = hit_r ? ram_rdata.size : '0;
    base          = total_r - TOTAL_W'(old_size);
    new_sum       = {1'b0, base} + (TOTAL_W+1)'(item_r.entry_size);

    unique case (state_r)
      // Accept an item and start the slot read
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          ram_raddr = in_item.entry_index[IDX_W-1:0];
          state_nxt = ST_READ;
        end
      end
      // Wait for the slot word
      ST_READ: begin
        hit_nxt   = valid_r[item_r.entry_index[IDX_W-1:0]];
        res_nxt   = '0;
        evict_nxt = 1'b0;
        state_nxt = ST_MODIFY;
      end
      // Apply the operation and write back the named slot where it changes
      ST_MODIFY: begin
        res_nxt.hit = hit_r;
        case (item_r.operation)
          OP_TOUCH: begin
            if (hit_r) begin
              upd.stamp = clock_r + STAMP_W'(1);
              clock_nxt = clock_r + STAMP_W'(1);
              ram_we    = 1'b1;
            end
          end
          OP_PUT: begin
            if (item_r.entry_size <= MAX_ASSET_BYTES && !new_sum[TOTAL_W]) begin
              upd.pinned = hit_r ? (ram_rdata.pinned | item_r.pin_request)
                                 : item_r.pin_request;
              upd.holds  = hit_r ? ram_rdata.holds : '0;
              upd.size   = item_r.entry_size;
              upd.stamp  = clock_r + STAMP_W'(1);
              clock_nxt  = clock_r + STAMP_W'(1);
              valid_nxt[item_r.entry_index[IDX_W-1:0]] = 1'b1;
              total_nxt  = new_sum[TOTAL_W-1:0];
              ram_we     = 1'b1;
              evict_nxt  = 1'b1;
            end
          end
          OP_HOLD: begin
            if (hit_r && ram_rdata.holds != HOLD_MAX) begin
              upd.holds = ram_rdata.holds + HOLD_W'(1);
              ram_we    = 1'b1;
            end
          end
          OP_UNHOLD: begin
            if (hit_r && ram_rdata.holds != '0) begin
              upd.holds = ram_rdata.holds - HOLD_W'(1);
              ram_we    = 1'b1;
            end
            evict_nxt = 1'b1;
          end
          OP_REMOVE: begin
            if (hit_r) begin
              total_nxt = total_r - TOTAL_W'(ram_rdata.size);
              valid_nxt[item_r.entry_index[IDX_W-1:0]] = 1'b0;
            end
          end
          OP_EVICT: evict_nxt = 1'b1;
          default: ;
        endcase
        ram_wdata = upd;
        state_nxt = ST_CHECK;
      end
      // Decide whether another victim is needed
      ST_CHECK: begin
        res_nxt.total_bytes = total_r;
        if (!evict_r) begin
          state_nxt = ST_OUT;
        end else if (total_r <= budget_r) begin
          reported_nxt = 1'b0;
          state_nxt    = ST_OUT;
        end else begin
          ram_raddr = '0;
          scan_nxt  = IDX_W'(1);
          found_nxt = 1'b0;
          state_nxt = (ENTRIES == 1) ? ST_SCAN_LAST : ST_SCAN;
        end
      end
      // Scan slot words one a cycle for the oldest candidate
      ST_SCAN, ST_SCAN_LAST: begin
        if (cand && older) begin
          found_nxt     = 1'b1;
          pick_nxt      = rd_idx;
          pick_slot_nxt = ram_rdata;
        end
        if (state_r == ST_SCAN) begin
          ram_raddr = scan_r;
          scan_nxt  = scan_r + IDX_W'(1);
          if (scan_r == IDX_W'(ENTRIES-1)) begin
            state_nxt = ST_SCAN_LAST;
          end
        end else begin
          if (!(found_r || (cand && older))) begin
            res_nxt.over_budget = 1'b1;
            if (!reported_r) begin
              reported_nxt            = 1'b1;
              res_nxt.over_budget_new = 1'b1;
            end
            state_nxt = ST_OUT;
          end else begin
            if (cand && older) begin
              pick_nxt = rd_idx;
              pick_slot_nxt = ram_rdata;
            end
            state_nxt = ST_CHECK;
            valid_nxt[(cand && older) ? rd_idx : pick_r] = 1'b0;
            total_nxt = total_r - TOTAL_W'((cand && older) ? ram_rdata.size
                                                          : pick_slot_r.size);
            res_nxt.freed_bytes = res_r.freed_bytes +
              TOTAL_W'((cand && older) ? ram_rdata.size : pick_slot_r.size);
            if (res_r.evicted_count != 5'd31) begin
              res_nxt.evicted_count = res_r.evicted_count + 5'd1;
            end
            res_nxt.evicted_mask[(cand && older) ? rd_idx : pick_r] = 1'b1;
          end
        end
      end
      // Present the result until transfer
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= '0;
      total_r    <= '0;
      clock_r    <= '0;
      reported_r <= 1'b0;
      evict_r    <= 1'b0;
      found_r    <= 1'b0;
      scan_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      total_r    <= total_nxt;
      clock_r    <= clock_nxt;
      reported_r <= reported_nxt;
      evict_r    <= evict_nxt;
      found_r    <= found_nxt;
      scan_r     <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    hit_r       <= hit_nxt;
    pick_r      <= pick_nxt;
    pick_slot_r <= pick_slot_nxt;
  end

  // An accepted item, taken only while no result is pending, starts a slot read
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_READ)
    else $error("accept did not start a slot read");

  // A result stays until transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // Over budget new implies over budget
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.over_budget_new || out_item.over_budget))
    else $error("new flag without over budget");

endmodule

// ===== rtl/core/bblru_ram.sv =====
// ============================================================================
// bblru_ram: generic single-port-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module bblru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/byte_budget_lru_evictor_tb.sv =====
// ----------------------------------------------------------------------------
// byte_budget_lru_evictor_tb: self-checking bench for the LRU evictor
// Drives operations with random gaps and output stalls, steps the byte budget
// through several values over the APB port, and checks every result against
// a cycle-free model of the slot table kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module byte_budget_lru_evictor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bblru_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 3000;
  localparam int RANDOM_ITEMS   = 800;

  // Slot table model and the queue of results it expects
  class lru_scoreboard;
    bit [TOTAL_W-1:0] budget;
    bit               valid  [ENTRIES];
    bit [SIZE_W-1:0]  size   [ENTRIES];
    bit               pinned [ENTRIES];
    bit [HOLD_W-1:0]  holds  [ENTRIES];
    bit [STAMP_W-1:0] stamp  [ENTRIES];
    bit [TOTAL_W-1:0] total;
    bit [STAMP_W-1:0] use_clock;
    bit               over_reported;
    out_item_t        pending[$];
    int               mismatches;

    function new();
      budget = TOTAL_MAX;
      foreach (valid[i]) valid[i] = 1'b0;
      total = '0;
      use_clock = '0;
      over_reported = 1'b0;
      mismatches = 0;
    endfunction

    // Drop oldest evictable slots until the total fits the budget
    function void evict_to_budget(ref out_item_t r);
      int pick;
      while (total > budget) begin
        pick = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i] && !pinned[i] && holds[i] == 0 &&
              (pick < 0 || stamp[i] < stamp[pick]))
            pick = i;
        if (pick < 0) begin
          r.over_budget = 1'b1;
          if (!over_reported) begin
            over_reported = 1'b1;
            r.over_budget_new = 1'b1;
          end
          break;
        end
        if (r.evicted_count < 31) r.evicted_count++;
        r.evicted_mask[pick] = 1'b1;
        r.freed_bytes += size[pick];
        total -= size[pick];
        valid[pick] = 1'b0;
      end
      if (total <= budget) over_reported = 1'b0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t        r;
      int               idx;
      bit               hit;
      bit [TOTAL_W:0]   base;
      idx = it.entry_index;
      hit = valid[idx];
      r = '0;
      r.hit = hit;
      case (it.operation)
        OP_TOUCH: if (hit) stamp[idx] = ++use_clock;
        OP_PUT: begin
          base = hit ? total - size[idx] : total;
          if (base + it.entry_size <= TOTAL_MAX) begin
            if (!hit) begin
              valid[idx] = 1'b1;
              holds[idx] = '0;
              pinned[idx] = it.pin_request;
            end else begin
              pinned[idx] = pinned[idx] | it.pin_request;
            end
            size[idx] = it.entry_size;
            stamp[idx] = ++use_clock;
            total = base + it.entry_size;
            evict_to_budget(r);
          end
        end
        OP_HOLD: if (hit && holds[idx] != HOLD_MAX) holds[idx]++;
        OP_UNHOLD: begin
          if (hit && holds[idx] != 0) holds[idx]--;
          evict_to_budget(r);
        end
        OP_REMOVE: begin
          if (hit) begin
            total -= size[idx];
            valid[idx] = 1'b0;
          end
        end
        OP_EVICT: evict_to_budget(r);
        default: ;
      endcase
      r.total_bytes = total;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      bit        bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending[0];
      pending.delete(0);
      bad = (got.hit != exp_r.hit) || (got.evicted_count != exp_r.evicted_count) ||
            (got.evicted_mask != exp_r.evicted_mask) ||
            (got.freed_bytes != exp_r.freed_bytes) ||
            (got.total_bytes != exp_r.total_bytes) ||
            (got.over_budget != exp_r.over_budget) ||
            (got.over_budget_new != exp_r.over_budget_new);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                   $realtime, exp_r, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lru_scoreboard sb;
  bit            long_hold_req;
  int            idle_cycles;

  byte_budget_lru_evictor u_top (.*);

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls: random short ones, a few long, quiet stretches, one long hold
  initial begin
    int pick;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
        long_hold_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          out_stall = 1'b0;
          repeat ($urandom_range(50, 200)) @(negedge clk);
        end else if (pick < 10) begin
          out_stall = 1'b1;
          repeat ($urandom_range(20, 80)) @(negedge clk);
          out_stall = 1'b0;
        end else begin
          out_stall = (pick < 35);
        end
      end
    end
  end

  // Send one item, holding it until the transfer
  task automatic send_item(in_item_t it);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_op(op_t op, int idx, int sz, bit pin);
    in_item_t it;
    it.operation = op;
    it.entry_index = 4'(idx);
    it.entry_size = SIZE_W'(sz);
    it.pin_request = pin;
    send_item(it);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Write the budget register while the block is idle
  task automatic write_budget(logic [31:0] value);
    drain();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = REG_BUDGET;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.budget = value[TOTAL_W-1:0];
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.operation = (pick < 35) ? OP_PUT : (pick < 50) ? OP_TOUCH :
                   (pick < 62) ? OP_HOLD : (pick < 74) ? OP_UNHOLD :
                   (pick < 84) ? OP_REMOVE : (pick < 94) ? OP_EVICT :
                   3'($urandom_range(6, 7));
    it.entry_index = 4'($urandom_range(0, ENTRIES - 1));
    pick = $urandom_range(0, 99);
    it.entry_size = (pick < 60) ? SIZE_W'($urandom_range(0, 4000)) :
                    (pick < 90) ? SIZE_W'($urandom_range(0, 1 << 20)) :
                    SIZE_W'($urandom);
    it.pin_request = ($urandom_range(0, 99) < 12);
    return it;
  endfunction

  initial begin
    logic [31:0] budgets[6];
    int          per_phase;
    int          slot;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    long_hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: field extremes and each operation at the reset budget
    send_op(OP_TOUCH, 3, 0, 1'b0);
    send_op(OP_PUT, 0, MAX_ASSET_BYTES, 1'b1);
    send_op(OP_PUT, 15, 0, 1'b0);
    send_op(OP_PUT, 7, 1000, 1'b0);
    send_op(OP_PUT, 7, 2000, 1'b1);
    send_op(OP_TOUCH, 15, 0, 1'b0);
    send_op(OP_HOLD, 15, 0, 1'b0);
    send_op(OP_HOLD, 4, 0, 1'b0);
    send_op(OP_UNHOLD, 15, 0, 1'b0);
    send_op(OP_UNHOLD, 15, 0, 1'b0);
    send_op(OP_REMOVE, 15, 0, 1'b0);
    send_op(OP_REMOVE, 15, 0, 1'b0);
    send_op(OP_EVICT, 9, 0, 1'b0);
    send_item({3'd6, 4'd1, 24'd5, 1'b1});
    send_item({3'd7, 4'd2, 24'd5, 1'b0});

    // Directed: zero budget leaves only pinned slots, flag is new only once
    write_budget(32'd0);
    send_op(OP_PUT, 3, 500, 1'b0);
    send_op(OP_HOLD, 0, 0, 1'b0);
    send_op(OP_EVICT, 0, 0, 1'b0);
    send_op(OP_EVICT, 0, 0, 1'b0);
    send_op(OP_REMOVE, 0, 0, 1'b0);
    send_op(OP_REMOVE, 7, 0, 1'b0);
    send_op(OP_EVICT, 0, 0, 1'b0);

    // Random phases at several budgets
    budgets = '{32'd20000, 32'd0, 32'hFFFF_FFFF, 32'd5000, 32'(TOTAL_MAX), 32'd300000};
    budgets[2] = $urandom;
    per_phase = RANDOM_ITEMS / 6;
    foreach (budgets[p]) begin
      write_budget(budgets[p]);
      if (p == 1) long_hold_req = 1'b1;
      for (int n = 0; n < per_phase; n++) begin
        // Saturate a hold count now and then
        if (n == 40 && p % 2 == 0) begin
          slot = $urandom_range(0, ENTRIES - 1);
          send_op(OP_PUT, slot, $urandom_range(0, 100), 1'b0);
          repeat (258) send_op(OP_HOLD, slot, 0, 1'b0);
          send_op(OP_UNHOLD, slot, 0, 1'b0);
        end
        if (n == per_phase / 2 && p == 3) drain();
        send_item(random_item());
      end
    end

    // Wait for the last results, then settle
    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bblru_pkg.sv
rtl/core/bblru_ram.sv
rtl/core/byte_budget_lru_evictor.sv
verif/byte_budget_lru_evictor_tb.sv
